>>> design/cetm_pkg.sv
// ----------------------------------------------------------------------------
// cetm_pkg: shared types and constants for the cron entry table matcher
// Holds the request and result payloads, the table entry layout and the codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cetm_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int OBJ_W  = 24;
    localparam int ATTR_W = 16;
    localparam int MIN_W  = 60;
    localparam int HOUR_W = 24;
    localparam int DAY_W  = 31;
    localparam int MON_W  = 12;
    localparam int WDAY_W = 8;
    localparam int TIME_W = 23;
    localparam int RMV_W  = 5;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CLEARED   = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    localparam logic [ATTR_W-1:0] ANY_ATTRIBUTE = 16'hFFFF;
    localparam logic [WDAY_W-1:0] SUNDAY_BITS   = 8'h81;
    localparam logic [RMV_W-1:0]  RMV_MAX       = 5'd31;

    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
    localparam logic [3:0] MONTHS_PER_YEAR  = 4'd12;

    typedef struct packed {
        logic [1:0]        operation;
        logic [OBJ_W-1:0]  object_id;
        logic [ATTR_W-1:0] attribute_id;
        logic [MIN_W-1:0]  minute_mask;
        logic [HOUR_W-1:0] hour_mask;
        logic [DAY_W-1:0]  day_mask;
        logic [MON_W-1:0]  month_mask;
        logic [WDAY_W-1:0] weekday_mask;
        logic              day_star;
        logic              weekday_star;
        logic [TIME_W-1:0] calendar_time;
    } in_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [OBJ_W-1:0]  fired_object;
        logic [ATTR_W-1:0] fired_attribute;
        logic [RMV_W-1:0]  removed_count;
        logic              last;
    } out_rsp_t;

    // stars[0] is the day-of-month star, stars[1] the weekday star
    typedef struct packed {
        logic [OBJ_W-1:0]  owner;
        logic [ATTR_W-1:0] attribute;
        logic [MIN_W-1:0]  minutes;
        logic [HOUR_W-1:0] hours;
        logic [DAY_W-1:0]  days;
        logic [MON_W-1:0]  months;
        logic [WDAY_W-1:0] weekdays;
        logic [1:0]        stars;
    } entry_t;

    typedef struct packed {
        logic dup_hit;
        logic clr_hit;
        logic tick_hit;
    } eval_flags_t;

endpackage

>>> design/cetm_entry_ram.sv
// ----------------------------------------------------------------------------
// cetm_entry_ram: cron entry storage
// One write port, one registered read port. No reset on the contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cetm_entry_ram #(
    parameter int DEPTH  = cetm_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  cetm_pkg::entry_t    wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output cetm_pkg::entry_t    rd_data
);

    cetm_pkg::entry_t mem [DEPTH];
    cetm_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/cetm_entry_eval.sv
// ----------------------------------------------------------------------------
// cetm_entry_eval: shared compare unit for one table entry
// Duplicate test, clear match and schedule match against the tick time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cetm_entry_eval (
    input  cetm_pkg::entry_t                  entry,
    input  cetm_pkg::entry_t                  key,
    input  logic [cetm_pkg::TIME_W-1:0]       cal_time,
    output cetm_pkg::eval_flags_t             flags
);

    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [2:0]  wday;
    logic [4:0]  day_idx;
    logic [3:0]  month_idx;
    logic [63:0] min_ext;
    logic [31:0] hour_ext;
    logic [31:0] day_ext;
    logic [15:0] mon_ext;
    logic        m_ok, h_ok, d_ok, mo_ok, w_ok, day_ok;

    assign minute    = cal_time[5:0];
    assign hour      = cal_time[10:6];
    assign day       = cal_time[15:11];
    assign month     = cal_time[19:16];
    assign wday      = cal_time[22:20];
    assign day_idx   = day - 5'd1;
    assign month_idx = month - 4'd1;

    // widen masks so every index the time fields can carry stays in range
    assign min_ext  = {4'b0, entry.minutes};
    assign hour_ext = {8'b0, entry.hours};
    assign day_ext  = {1'b0, entry.days};
    assign mon_ext  = {4'b0, entry.months};

    assign m_ok  = (minute < cetm_pkg::MINUTES_PER_HOUR) && min_ext[minute];
    assign h_ok  = (hour < cetm_pkg::HOURS_PER_DAY) && hour_ext[hour];
    assign d_ok  = (day != 5'd0) && day_ext[day_idx];
    assign mo_ok = (month != 4'd0) && (month <= cetm_pkg::MONTHS_PER_YEAR)
                   && mon_ext[month_idx];
    assign w_ok  = entry.weekdays[wday];

    // either star flag: both day fields must hit, else either may
    assign day_ok = (entry.stars != 2'b00) ? (d_ok && w_ok) : (d_ok || w_ok);

    assign flags.dup_hit  = (entry == key);
    assign flags.clr_hit  = (entry.owner == key.owner) &&
                            ((key.attribute == cetm_pkg::ANY_ATTRIBUTE) ||
                             (entry.attribute == key.attribute));
    assign flags.tick_hit = m_ok && h_ok && mo_ok && day_ok;

endmodule

>>> design/cron_entry_table_matcher.sv
// ----------------------------------------------------------------------------
// cron_entry_table_matcher: bounded cron table with insert, clear and tick
// Walk: each request reads the live entries in turn and then gives its final result
//   (per entry: RAM read, then compare; an insert stops at a duplicate, a
//   disabled tick walks none); a stalled result side can hold the walk up.
// A new request is accepted only once the last is finished; code 3 is dropped with no result.
// Reset: synchronous, active low; table empties (count 0), cron_enable set to 1.
//   Entry storage is not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cron_entry_table_matcher #(
    parameter int TABLE_ENTRIES = cetm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  cetm_pkg::in_req_t   s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output cetm_pkg::out_rsp_t  m_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // request held for the whole walk
    logic [1:0]                    op_reg;
    cetm_pkg::entry_t              key_reg;
    cetm_pkg::entry_t              key_in;
    logic [cetm_pkg::TIME_W-1:0]   time_reg;
    logic [cetm_pkg::WDAY_W-1:0]   wday_fold;

    // walk control
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              kept_reg, kept_next;
    logic [cetm_pkg::RMV_W-1:0]    removed_reg, removed_next;
    logic                          dup_reg, dup_next;
    logic                          cron_enable_reg;

    // newest match not yet sent; held back so the final one can carry last
    logic                          pend_valid_reg, pend_valid_next;
    logic [cetm_pkg::OBJ_W-1:0]    pend_obj_reg, pend_obj_next;
    logic [cetm_pkg::ATTR_W-1:0]   pend_attr_reg, pend_attr_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    cetm_pkg::out_rsp_t            m_data_reg;
    logic                          push;
    cetm_pkg::out_rsp_t            push_data;
    logic                          out_free;

    // entry RAM and compare unit
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    cetm_pkg::entry_t              wr_data;
    cetm_pkg::entry_t              rd_data;
    cetm_pkg::eval_flags_t         flags;

    logic                          s_fire;
    logic                          walk_end_up;
    logic                          walk_end_down;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign walk_end_up   = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign walk_end_down = (idx_reg == '0);

    // Sunday sits on both bit 0 and bit 7
    always_comb begin
        wday_fold = s_data.weekday_mask;
        if ((s_data.weekday_mask & cetm_pkg::SUNDAY_BITS) != '0) begin
            wday_fold = s_data.weekday_mask | cetm_pkg::SUNDAY_BITS;
        end
    end

    always_comb begin
        key_in.owner     = s_data.object_id;
        key_in.attribute = s_data.attribute_id;
        key_in.minutes   = s_data.minute_mask;
        key_in.hours     = s_data.hour_mask;
        key_in.days      = s_data.day_mask;
        key_in.months    = s_data.month_mask;
        key_in.weekdays  = wday_fold;
        key_in.stars     = {s_data.weekday_star, s_data.day_star};
    end

    cetm_entry_ram #(
        .DEPTH   (TABLE_ENTRIES),
        .ADDR_W  (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    cetm_entry_eval u_eval (
        .entry    (rd_data),
        .key      (key_reg),
        .cal_time (time_reg),
        .flags    (flags)
    );

    // Sequencer. READ presents idx to the RAM, EVAL sees its registered data in the cycle after.
    // Clear compacts in place: survivors are written back at kept <= idx.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        kept_next       = kept_reg;
        removed_next    = removed_reg;
        dup_next        = dup_reg;
        pend_valid_next = pend_valid_reg;
        pend_obj_next   = pend_obj_reg;
        pend_attr_next  = pend_attr_reg;
        push            = 1'b0;
        push_data       = '0;
        wr_en           = 1'b0;
        wr_addr         = kept_reg[IDX_W-1:0];
        wr_data         = rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.operation)
                        cetm_pkg::OP_INSERT: begin
                            dup_next   = 1'b0;
                            idx_next   = '0;
                            state_next = (cnt_reg == '0) ? S_FINISH : S_READ;
                        end
                        cetm_pkg::OP_CLEAR: begin
                            kept_next    = '0;
                            removed_next = '0;
                            idx_next     = '0;
                            state_next   = (cnt_reg == '0) ? S_FINISH : S_READ;
                        end
                        cetm_pkg::OP_TICK: begin
                            pend_valid_next = 1'b0;
                            idx_next        = IDX_W'(cnt_reg - CNT_W'(1));
                            state_next      = ((cnt_reg == '0) || !cron_enable_reg) ?
                                              S_FINISH : S_READ;
                        end
                        default: begin
                            state_next = S_IDLE;   // unknown op: dropped, no result
                        end
                    endcase
                end
            end

            S_READ: begin
                state_next = S_EVAL;
            end

            S_EVAL: begin
                unique case (op_reg)
                    cetm_pkg::OP_INSERT: begin
                        if (flags.dup_hit) begin
                            dup_next   = 1'b1;
                            state_next = S_FINISH;
                        end else if (walk_end_up) begin
                            state_next = S_FINISH;
                        end else begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    cetm_pkg::OP_CLEAR: begin
                        if (flags.clr_hit) begin
                            if (removed_reg != cetm_pkg::RMV_MAX) begin
                                removed_next = removed_reg + cetm_pkg::RMV_W'(1);
                            end
                        end else begin
                            wr_en     = 1'b1;
                            kept_next = kept_reg + CNT_W'(1);
                        end
                        if (walk_end_up) begin
                            state_next = S_FINISH;
                        end else begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    cetm_pkg::OP_TICK: begin
                        // a new hit must first push the held one out
                        if (!(flags.tick_hit && pend_valid_reg && !out_free)) begin
                            if (flags.tick_hit) begin
                                if (pend_valid_reg) begin
                                    push                      = 1'b1;
                                    push_data.status          = cetm_pkg::ST_FIRED;
                                    push_data.fired_object    = pend_obj_reg;
                                    push_data.fired_attribute = pend_attr_reg;
                                end
                                pend_valid_next = 1'b1;
                                pend_obj_next   = rd_data.owner;
                                pend_attr_next  = rd_data.attribute;
                            end
                            if (walk_end_down) begin
                                state_next = S_FINISH;
                            end else begin
                                idx_next   = idx_reg - IDX_W'(1);
                                state_next = S_READ;
                            end
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FINISH: begin
                if (out_free) begin
                    push           = 1'b1;
                    push_data.last = 1'b1;
                    state_next     = S_IDLE;
                    unique case (op_reg)
                        cetm_pkg::OP_INSERT: begin
                            if (dup_reg) begin
                                push_data.status = cetm_pkg::ST_DUPLICATE;
                            end else if (cnt_reg >= CNT_W'(TABLE_ENTRIES)) begin
                                push_data.status = cetm_pkg::ST_FULL;
                            end else begin
                                wr_en            = 1'b1;
                                wr_addr          = cnt_reg[IDX_W-1:0];
                                wr_data          = key_reg;
                                cnt_next         = cnt_reg + CNT_W'(1);
                                push_data.status = cetm_pkg::ST_INSERTED;
                            end
                        end
                        cetm_pkg::OP_CLEAR: begin
                            cnt_next                = kept_reg;
                            push_data.status        = cetm_pkg::ST_CLEARED;
                            push_data.removed_count = removed_reg;
                        end
                        cetm_pkg::OP_TICK: begin
                            if (pend_valid_reg) begin
                                push_data.status          = cetm_pkg::ST_FIRED;
                                push_data.fired_object    = pend_obj_reg;
                                push_data.fired_attribute = pend_attr_reg;
                            end else begin
                                push_data.status = cetm_pkg::ST_NONE;
                            end
                            pend_valid_next = 1'b0;
                        end
                        default: begin
                            push = 1'b0;
                        end
                    endcase
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            cron_enable_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            dup_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            dup_reg        <= dup_next;
            if (cfg_wr_en) begin
                cron_enable_reg <= cfg_wr_data;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        kept_reg      <= kept_next;
        removed_reg   <= removed_next;
        pend_obj_reg  <= pend_obj_next;
        pend_attr_reg <= pend_attr_next;
        if (s_fire) begin
            op_reg   <= s_data.operation;
            key_reg  <= key_in;
            time_reg <= s_data.calendar_time;
        end
        if (push) begin
            m_data_reg <= push_data;
        end
    end

endmodule

>>> sim/tb_cron_entry_table_matcher.sv
// ----------------------------------------------------------------------------
// tb_cron_entry_table_matcher: self-checking bench for the cron entry table
// Drives insert, clear and minute-tick requests, predicts every result from a
// behavioural copy of the table, and checks each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cron_entry_table_matcher;

    localparam int TABLE_DEPTH     = cetm_pkg::TABLE_ENTRIES_DEF;
    // settle time once nothing is awaited: a full table walk plus margin
    localparam int SETTLE_CYCLES   = 2 * TABLE_DEPTH + 12;
    localparam int STALL_LIMIT     = 5000;  // cycles with no handshake at all
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_PRINTED     = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    cetm_pkg::in_req_t   s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    cetm_pkg::out_rsp_t  m_data;

    // behavioural copy of the table: oldest at 0, newest at table_count-1
    cetm_pkg::entry_t    cron_table [TABLE_DEPTH];
    int                  table_count  = 0;
    logic                table_enable = 1'b1;
    cetm_pkg::out_rsp_t  outcome_q [$];

    logic [cetm_pkg::OBJ_W-1:0]  owner_pool [6];
    logic [cetm_pkg::ATTR_W-1:0] attr_pool  [4];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int idle_cycles   = 0;
    int error_count   = 0;

    cron_entry_table_matcher #(
        .TABLE_ENTRIES (TABLE_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_result(input logic [2:0] st,
                                        input logic [cetm_pkg::OBJ_W-1:0] obj,
                                        input logic [cetm_pkg::ATTR_W-1:0] attr,
                                        input logic [cetm_pkg::RMV_W-1:0] removed,
                                        input logic fin);
        cetm_pkg::out_rsp_t r;
        r.status          = st;
        r.fired_object    = obj;
        r.fired_attribute = attr;
        r.removed_count   = removed;
        r.last            = fin;
        outcome_q.push_back(r);
    endfunction

    // Applies one accepted request to the table copy and queues its results.
    function automatic void predict_outcome(input cetm_pkg::in_req_t req);
        cetm_pkg::entry_t cand;
        cetm_pkg::entry_t e;
        logic [5:0]       minute;
        logic [4:0]       hour;
        logic [4:0]       day;
        logic [3:0]       month;
        logic [2:0]       wday;
        logic             m_ok, h_ok, d_ok, mo_ok, w_ok, day_ok;
        int               kept, removed, fired;
        case (req.operation)
            cetm_pkg::OP_INSERT: begin
                cand.owner     = req.object_id;
                cand.attribute = req.attribute_id;
                cand.minutes   = req.minute_mask;
                cand.hours     = req.hour_mask;
                cand.days      = req.day_mask;
                cand.months    = req.month_mask;
                cand.weekdays  = req.weekday_mask;
                cand.stars     = {req.weekday_star, req.day_star};
                // either Sunday bit sets both
                if ((cand.weekdays & cetm_pkg::SUNDAY_BITS) != '0) begin
                    cand.weekdays |= cetm_pkg::SUNDAY_BITS;
                end
                // duplicate wins over a full table
                for (int i = 0; i < table_count; i++) begin
                    if (cron_table[i] == cand) begin
                        push_result(cetm_pkg::ST_DUPLICATE, '0, '0, '0, 1'b1);
                        return;
                    end
                end
                if (table_count >= TABLE_DEPTH) begin
                    push_result(cetm_pkg::ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    cron_table[table_count] = cand;
                    table_count++;
                    push_result(cetm_pkg::ST_INSERTED, '0, '0, '0, 1'b1);
                end
            end
            cetm_pkg::OP_CLEAR: begin
                kept    = 0;
                removed = 0;
                for (int i = 0; i < table_count; i++) begin
                    if (cron_table[i].owner == req.object_id &&
                        (req.attribute_id == cetm_pkg::ANY_ATTRIBUTE ||
                         cron_table[i].attribute == req.attribute_id)) begin
                        removed++;
                    end else begin
                        cron_table[kept] = cron_table[i];
                        kept++;
                    end
                end
                table_count = kept;
                push_result(cetm_pkg::ST_CLEARED, '0, '0,
                            (removed > 31) ? cetm_pkg::RMV_MAX
                                           : removed[cetm_pkg::RMV_W-1:0], 1'b1);
            end
            cetm_pkg::OP_TICK: begin
                minute = req.calendar_time[5:0];
                hour   = req.calendar_time[10:6];
                day    = req.calendar_time[15:11];
                month  = req.calendar_time[19:16];
                wday   = req.calendar_time[22:20];
                fired  = 0;
                if (table_enable) begin
                    // newest first
                    for (int i = table_count - 1; i >= 0; i--) begin
                        e      = cron_table[i];
                        m_ok   = (minute < cetm_pkg::MINUTES_PER_HOUR) ?
                                 e.minutes[minute] : 1'b0;
                        h_ok   = (hour < cetm_pkg::HOURS_PER_DAY) ? e.hours[hour] : 1'b0;
                        d_ok   = (day != '0) ? e.days[day - 1] : 1'b0;
                        mo_ok  = (month != '0 && month <= cetm_pkg::MONTHS_PER_YEAR) ?
                                 e.months[month - 1] : 1'b0;
                        w_ok   = e.weekdays[wday];
                        // a starred day field forces both day tests
                        day_ok = (e.stars != '0) ? (d_ok && w_ok) : (d_ok || w_ok);
                        if (m_ok && h_ok && mo_ok && day_ok) begin
                            push_result(cetm_pkg::ST_FIRED, e.owner, e.attribute,
                                        '0, 1'b0);
                            fired++;
                        end
                    end
                end
                if (fired == 0) begin
                    push_result(cetm_pkg::ST_NONE, '0, '0, '0, 1'b1);
                end else begin
                    outcome_q[outcome_q.size() - 1].last = 1'b1;
                end
            end
            default: ;  // unused code: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    // Every field random; builders overwrite what the operation uses, so
    // the ignored fields still see every bit toggle.
    function automatic cetm_pkg::in_req_t noise_request();
        logic [223:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom()};
        return raw[$bits(cetm_pkg::in_req_t)-1:0];
    endfunction

    function automatic cetm_pkg::in_req_t insert_request(
        input logic [cetm_pkg::OBJ_W-1:0] obj, input logic [cetm_pkg::ATTR_W-1:0] attr,
        input logic [cetm_pkg::MIN_W-1:0] mins, input logic [cetm_pkg::HOUR_W-1:0] hrs,
        input logic [cetm_pkg::DAY_W-1:0] days, input logic [cetm_pkg::MON_W-1:0] mons,
        input logic [cetm_pkg::WDAY_W-1:0] wdays, input logic dstar, input logic wstar);
        cetm_pkg::in_req_t r;
        r              = noise_request();
        r.operation    = cetm_pkg::OP_INSERT;
        r.object_id    = obj;
        r.attribute_id = attr;
        r.minute_mask  = mins;
        r.hour_mask    = hrs;
        r.day_mask     = days;
        r.month_mask   = mons;
        r.weekday_mask = wdays;
        r.day_star     = dstar;
        r.weekday_star = wstar;
        return r;
    endfunction

    function automatic cetm_pkg::in_req_t clear_request(
        input logic [cetm_pkg::OBJ_W-1:0] obj, input logic [cetm_pkg::ATTR_W-1:0] attr);
        cetm_pkg::in_req_t r;
        r              = noise_request();
        r.operation    = cetm_pkg::OP_CLEAR;
        r.object_id    = obj;
        r.attribute_id = attr;
        return r;
    endfunction

    function automatic cetm_pkg::in_req_t tick_request(
        input logic [cetm_pkg::TIME_W-1:0] t);
        cetm_pkg::in_req_t r;
        r               = noise_request();
        r.operation     = cetm_pkg::OP_TICK;
        r.calendar_time = t;
        return r;
    endfunction

    function automatic logic [cetm_pkg::TIME_W-1:0] calendar(
        input int mn, input int hr, input int dy, input int mo, input int wd);
        return {wd[2:0], mo[3:0], dy[4:0], hr[4:0], mn[5:0]};
    endfunction

    // Random set bit of a mask, scanning from a random start.
    function automatic int pick_set_bit(input logic [63:0] m, input int width);
        int start;
        int idx;
        start = $urandom_range(0, width - 1);
        for (int k = 0; k < width; k++) begin
            idx = (start + k) % width;
            if (m[idx]) return idx;
        end
        return start;
    endfunction

    // A time that hits every field of the given entry.
    function automatic logic [cetm_pkg::TIME_W-1:0] time_hitting(
        input cetm_pkg::entry_t e);
        return calendar(pick_set_bit(64'(e.minutes), cetm_pkg::MIN_W),
                        pick_set_bit(64'(e.hours), cetm_pkg::HOUR_W),
                        pick_set_bit(64'(e.days), cetm_pkg::DAY_W) + 1,
                        pick_set_bit(64'(e.months), cetm_pkg::MON_W) + 1,
                        pick_set_bit(64'(e.weekdays), cetm_pkg::WDAY_W));
    endfunction

    // Mostly dense masks so that ticks match several entries at once.
    function automatic logic [63:0] draw_mask(input int width);
        logic [63:0] m;
        case ($urandom_range(0, 3))
            0:       m = '1;
            1:       m = {$urandom(), $urandom()};
            2:       m = 64'd1 << $urandom_range(0, width - 1);
            default: m = {$urandom(), $urandom()} | {$urandom(), $urandom()};
        endcase
        return m & ((64'd1 << width) - 1);
    endfunction

    // One random request, shaped by the current table contents.
    function automatic cetm_pkg::in_req_t draw_request();
        cetm_pkg::in_req_t           r;
        cetm_pkg::entry_t            e;
        logic [63:0]                 mm, mh, md, mo, mw;
        logic [cetm_pkg::WDAY_W-1:0] w;
        logic [cetm_pkg::TIME_W-1:0] raw_time;
        int                          roll;
        r        = noise_request();
        raw_time = r.calendar_time;
        roll     = $urandom_range(0, 99);
        if (table_count > 0) begin
            e = cron_table[$urandom_range(0, table_count - 1)];
        end
        if (roll < 40) begin
            mm = draw_mask(cetm_pkg::MIN_W);
            mh = draw_mask(cetm_pkg::HOUR_W);
            md = draw_mask(cetm_pkg::DAY_W);
            mo = draw_mask(cetm_pkg::MON_W);
            mw = draw_mask(cetm_pkg::WDAY_W);
            r  = insert_request(owner_pool[$urandom_range(0, 5)],
                                attr_pool[$urandom_range(0, 3)],
                                mm[cetm_pkg::MIN_W-1:0], mh[cetm_pkg::HOUR_W-1:0],
                                md[cetm_pkg::DAY_W-1:0], mo[cetm_pkg::MON_W-1:0],
                                mw[cetm_pkg::WDAY_W-1:0], r.day_star, r.weekday_star);
        end else if (roll < 50 && table_count > 0) begin
            // re-insert a live entry, Sunday given in either form
            w = e.weekdays;
            if (w == (w | cetm_pkg::SUNDAY_BITS)) begin
                case ($urandom_range(0, 2))
                    0:       w = w & ~8'h80;
                    1:       w = w & ~8'h01;
                    default: ;
                endcase
            end
            r = insert_request(e.owner, e.attribute, e.minutes, e.hours, e.days,
                               e.months, w, e.stars[0], e.stars[1]);
        end else if (roll < 62) begin
            if (table_count > 0 && $urandom_range(0, 1) == 1) begin
                r = clear_request(e.owner,
                                  ($urandom_range(0, 1) == 1) ? cetm_pkg::ANY_ATTRIBUTE
                                                              : e.attribute);
            end else begin
                r = clear_request(owner_pool[$urandom_range(0, 5)],
                                  attr_pool[$urandom_range(0, 3)]);
            end
        end else if (roll < 92 && table_count > 0) begin
            r = tick_request(time_hitting(e));
            // now and then spoil one day field to exercise the day rule
            case ($urandom_range(0, 5))
                0:       r.calendar_time[22:20] = raw_time[22:20];
                1:       r.calendar_time[15:11] = raw_time[15:11];
                default: ;
            endcase
        end else if (roll < 97) begin
            r.operation = cetm_pkg::OP_TICK;  // fully random time, often out of range
        end else begin
            r.operation = OP_UNUSED;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    // Offers one request and predicts it once accepted. Valid is left high
    // so that a back-to-back request costs no bubble.
    task automatic send_request(input cetm_pkg::in_req_t req);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, SETTLE_CYCLES);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_outcome(req);
    endtask

    // Stops offering, waits for every awaited result, then lets the block
    // finish any walk that produces nothing.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_enable(input logic value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        table_enable  = value;
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern, long hold-off, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        cetm_pkg::out_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no request awaiting it, status",
                                m_data.status, cetm_pkg::ST_NONE);
            end else begin
                want = outcome_q.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.fired_object !== want.fired_object)
                    report_mismatch("fired_object", m_data.fired_object, want.fired_object);
                if (m_data.fired_attribute !== want.fired_attribute)
                    report_mismatch("fired_attribute", m_data.fired_attribute,
                                    want.fired_attribute);
                if (m_data.removed_count !== want.removed_count)
                    report_mismatch("removed_count", m_data.removed_count,
                                    want.removed_count);
                if (m_data.last !== want.last)
                    report_mismatch("last", m_data.last, want.last);
            end
        end
    end

    // A hung block shows up as a long run with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_cron_entry_table_matcher failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_tick();
        send_request(tick_request(calendar(0, 0, 1, 1, 0)));
    endtask

    // Table after this: A (any time), B (last minute of the year, day star),
    // C (Sunday only), D (weekday star with no day of month: never fires).
    task automatic test_insert_and_fold();
        send_request(insert_request(24'hFFFFFF, 16'h0000, '1, '1, '1, '1,
                                    8'h01, 1'b0, 1'b0));
        // same entry with Sunday given as bit 7: folds to a duplicate
        send_request(insert_request(24'hFFFFFF, 16'h0000, '1, '1, '1, '1,
                                    8'h80, 1'b0, 1'b0));
        send_request(insert_request(24'h000000, cetm_pkg::ANY_ATTRIBUTE, {1'b1, 59'd0},
                                    {1'b1, 23'd0}, {1'b1, 30'd0}, {1'b1, 11'd0},
                                    8'h40, 1'b1, 1'b0));
        send_request(insert_request(24'h005A5A, 16'h1234, '1, '1, '0, '1,
                                    8'h01, 1'b0, 1'b0));
        send_request(insert_request(24'h005A5A, 16'h4321, '1, '1, '0, '1,
                                    8'hFF, 1'b0, 1'b1));
    endtask

    task automatic test_tick_match();
        send_request(tick_request(calendar(59, 23, 31, 12, 6)));
        // weekday 7 means Sunday
        send_request(tick_request(calendar(0, 0, 1, 1, 7)));
        // out-of-range minute, hour, day and month
        send_request(tick_request(calendar(60, 23, 31, 12, 6)));
        send_request(tick_request(calendar(0, 24, 0, 0, 0)));
        send_request(tick_request(calendar(0, 0, 1, 13, 0)));
    endtask

    task automatic test_enable_register();
        drain_and_settle();
        write_enable(1'b0);
        send_request(tick_request(calendar(0, 0, 1, 1, 7)));
        drain_and_settle();
        write_enable(1'b1);
    endtask

    task automatic test_clear();
        send_request(clear_request(24'hFFFFFF, 16'h0000));
        send_request(clear_request(24'h005A5A, cetm_pkg::ANY_ATTRIBUTE));
        send_request(clear_request(24'h123456, cetm_pkg::ANY_ATTRIBUTE));
        send_request(noise_request() |
                     {2'b11, {($bits(cetm_pkg::in_req_t) - 2){1'b0}}});
    endtask

    // B is still live, so fifteen more fill the table.
    task automatic test_table_full();
        for (int a = 0; a < TABLE_DEPTH - 1; a++) begin
            send_request(insert_request(24'h00A5A5, a[cetm_pkg::ATTR_W-1:0],
                                        '1, '1, '1, '1, 8'hFF, 1'b0, 1'b0));
        end
        send_request(insert_request(24'h00A5A5, 16'd15, '1, '1, '1, '1, 8'hFF, 1'b0, 1'b0));
        send_request(insert_request(24'h00A5A5, 16'd7, '1, '1, '1, '1, 8'hFF, 1'b0, 1'b0));
        send_request(tick_request(calendar(59, 23, 31, 12, 6)));
    endtask

    // Receiver holds off while full-table ticks keep coming, so the block
    // backs up and stalls its request side; then the sender waits it out.
    task automatic test_result_backpressure();
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (6) send_request(tick_request(calendar(59, 23, 31, 12, 6)));
        drain_and_settle();
        send_request(clear_request(24'h00A5A5, cetm_pkg::ANY_ATTRIBUTE));
    endtask

    task automatic test_random_traffic(input int n_items);
        cetm_pkg::in_req_t req;
        int                sent;
        bit                toggled;
        sent    = 0;
        toggled = 1'b0;
        while (sent < n_items) begin
            // a short stretch with matching switched off, mid-phase
            if (!toggled && sent >= n_items / 2) begin
                toggled = 1'b1;
                drain_and_settle();
                write_enable(1'b0);
                repeat (6) send_request(draw_request());
                drain_and_settle();
                write_enable(1'b1);
            end
            req = draw_request();
            send_request(req);
            if (req.operation != OP_UNUSED) sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] draw;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 38;
        recv_idle_pct = 64;
        write_enable(1'b1);
        test_empty_tick();
        test_insert_and_fold();
        test_tick_match();
        test_enable_register();
        test_clear();
        test_table_full();
        test_result_backpressure();

        // small pools so that duplicates and clears actually hit
        for (int k = 0; k < 6; k++) begin
            draw          = $urandom();
            owner_pool[k] = draw[cetm_pkg::OBJ_W-1:0];
        end
        draw         = $urandom();
        attr_pool[0] = '0;
        attr_pool[1] = cetm_pkg::ANY_ATTRIBUTE;
        attr_pool[2] = draw[15:0];
        attr_pool[3] = draw[31:16];

        test_random_traffic(100);
        send_idle_pct = 64;
        recv_idle_pct = 38;
        test_random_traffic(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        drain_and_settle();
        if (error_count == 0) begin
            $display("tb_cron_entry_table_matcher passed");
        end else begin
            $display("tb_cron_entry_table_matcher failed");
        end
        $finish;
    end

endmodule
